/* design/mopb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mopb_pkg
// Shared widths, register indexes, depth codes and the divide-by-max helper
// used by the masked opacity pixel blend pipeline.
// ----------------------------------------------------------------------------
package mopb_pkg;

    localparam int PIX_W   = 16;
    localparam int PROD_W  = 2 * PIX_W;
    localparam int DEPTH_W = 3;
    localparam int BITS_W  = 5;

    // configuration register indexes
    localparam logic REG_DEPTH   = 1'b0;
    localparam logic REG_OPACITY = 1'b1;

    // depth select codes
    localparam logic [DEPTH_W-1:0] DEPTH_8  = 3'd0;
    localparam logic [DEPTH_W-1:0] DEPTH_10 = 3'd1;
    localparam logic [DEPTH_W-1:0] DEPTH_12 = 3'd2;
    localparam logic [DEPTH_W-1:0] DEPTH_14 = 3'd3;
    localparam logic [DEPTH_W-1:0] DEPTH_16 = 3'd4;

    // weighted pixel word passed from the weight stages to the mix stages
    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] base;
        logic [PIX_W-1:0] over;
        logic [PIX_W-1:0] weight;
    } mopb_wt_t;

    // pixel bit count for a depth code, unused codes select 16 bits
    function automatic logic [BITS_W-1:0] depth_bits(input logic [DEPTH_W-1:0] sel);
        logic [BITS_W-1:0] bits;
        begin
            case (sel)
                DEPTH_8:  bits = 5'd8;
                DEPTH_10: bits = 5'd10;
                DEPTH_12: bits = 5'd12;
                DEPTH_14: bits = 5'd14;
                DEPTH_16: bits = 5'd16;
                default:  bits = 5'd16;
            endcase
            return bits;
        end
    endfunction

    // largest pixel value at a depth code: 2^bits - 1
    function automatic logic [PIX_W-1:0] max_of(input logic [DEPTH_W-1:0] sel);
        logic [PIX_W:0] one_up;
        begin
            one_up = (PIX_W+1)'(1) << depth_bits(sel);
            return PIX_W'(one_up - (PIX_W+1)'(1));
        end
    endfunction

    // clamp a value to the pixel maximum
    function automatic logic [PIX_W-1:0] sat_to(input logic [PIX_W-1:0] v,
                                                input logic [PIX_W-1:0] lim);
        begin
            return (v > lim) ? lim : v;
        end
    endfunction

    // floor(x / max) for x <= max*max + max/2
    // x = a*2^b + c = a*max + (a + c), and a + c stays below 2*max
    function automatic logic [PIX_W-1:0] div_by_max(input logic [PROD_W-1:0] x,
                                                    input logic [DEPTH_W-1:0] sel);
        logic [PROD_W-1:0] hi;
        logic [PIX_W-1:0]  a;
        logic [PIX_W-1:0]  c;
        logic [PIX_W-1:0]  mx;
        logic [PIX_W:0]    s;
        begin
            mx = max_of(sel);
            hi = x >> depth_bits(sel);
            a  = hi[PIX_W-1:0];
            c  = x[PIX_W-1:0] & mx;
            s  = {1'b0, a} + {1'b0, c};
            return a + ((s >= {1'b0, mx}) ? PIX_W'(1) : PIX_W'(0));
        end
    endfunction

endpackage

/* design/mopb_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mopb_cfg
// Configuration registers: pixel depth select and global opacity.
// ----------------------------------------------------------------------------
module mopb_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic                          wr_index,
    input  logic [mopb_pkg::PIX_W-1:0]    wr_data,
    output logic [mopb_pkg::DEPTH_W-1:0]  depth_sel,
    output logic [mopb_pkg::PIX_W-1:0]    opacity
);

    logic [mopb_pkg::DEPTH_W-1:0] depth_reg;
    logic [mopb_pkg::PIX_W-1:0]   opacity_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg   <= mopb_pkg::DEPTH_8;
            opacity_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                mopb_pkg::REG_DEPTH:   depth_reg   <= wr_data[mopb_pkg::DEPTH_W-1:0];
                mopb_pkg::REG_OPACITY: opacity_reg <= wr_data;
                default:               depth_reg   <= depth_reg;
            endcase
        end
    end

    assign depth_sel = depth_reg;
    assign opacity   = opacity_reg;

endmodule

/* design/mopb_weight.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mopb_weight
// Four-stage pipeline: clamp inputs, multiply mask by opacity, add rounding
// half, divide by max to give the effective weight.
// ----------------------------------------------------------------------------
module mopb_weight
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [mopb_pkg::PIX_W-1:0]    base_pixel,
    input  logic [mopb_pkg::PIX_W-1:0]    overlay_pixel,
    input  logic [mopb_pkg::PIX_W-1:0]    mask_value,
    input  logic [mopb_pkg::DEPTH_W-1:0]  depth_sel,
    input  logic [mopb_pkg::PIX_W-1:0]    opacity,
    output mopb_pkg::mopb_wt_t            wt_out
);

    logic [mopb_pkg::PIX_W-1:0]  max_val;
    logic [mopb_pkg::PIX_W-1:0]  half_val;

    logic                        v1_reg, v2_reg, v3_reg, v4_reg;
    logic [mopb_pkg::PIX_W-1:0]  base1_reg, over1_reg, mask1_reg, opac1_reg;
    logic [mopb_pkg::PIX_W-1:0]  base2_reg, over2_reg;
    logic [mopb_pkg::PROD_W-1:0] prod2_reg;
    logic [mopb_pkg::PIX_W-1:0]  base3_reg, over3_reg;
    logic [mopb_pkg::PROD_W-1:0] sum3_reg;
    logic [mopb_pkg::PIX_W-1:0]  base4_reg, over4_reg, wt4_reg;

    logic [mopb_pkg::PROD_W-1:0] prod2_next;
    logic [mopb_pkg::PROD_W-1:0] sum3_next;
    logic [mopb_pkg::PIX_W-1:0]  wt4_next;

    assign max_val  = mopb_pkg::max_of(depth_sel);
    assign half_val = max_val >> 1;

    // stage arithmetic
    always_comb
    begin
        prod2_next = mopb_pkg::PROD_W'(mask1_reg) * mopb_pkg::PROD_W'(opac1_reg);
        sum3_next  = prod2_reg + mopb_pkg::PROD_W'(half_val);
        wt4_next   = mopb_pkg::div_by_max(sum3_reg, depth_sel);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // data stages
    always_ff @(posedge clk)
    begin
        base1_reg <= mopb_pkg::sat_to(base_pixel, max_val);
        over1_reg <= mopb_pkg::sat_to(overlay_pixel, max_val);
        mask1_reg <= mopb_pkg::sat_to(mask_value, max_val);
        opac1_reg <= mopb_pkg::sat_to(opacity, max_val);

        base2_reg <= base1_reg;
        over2_reg <= over1_reg;
        prod2_reg <= prod2_next;

        base3_reg <= base2_reg;
        over3_reg <= over2_reg;
        sum3_reg  <= sum3_next;

        base4_reg <= base3_reg;
        over4_reg <= over3_reg;
        wt4_reg   <= wt4_next;
    end

    assign wt_out.valid  = v4_reg;
    assign wt_out.base   = base4_reg;
    assign wt_out.over   = over4_reg;
    assign wt_out.weight = wt4_reg;

endmodule

/* design/mopb_mix.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mopb_mix
// Four-stage pipeline: form inverse weight, multiply both pixels, sum with
// rounding half, divide by max into the output register.
// ----------------------------------------------------------------------------
module mopb_mix
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  mopb_pkg::mopb_wt_t            wt_in,
    input  logic [mopb_pkg::DEPTH_W-1:0]  depth_sel,
    output logic                          out_valid,
    output logic [mopb_pkg::PIX_W-1:0]    out_pixel
);

    logic [mopb_pkg::PIX_W-1:0]  max_val;
    logic [mopb_pkg::PIX_W-1:0]  half_val;

    logic                        v5_reg, v6_reg, v7_reg, v8_reg;
    logic [mopb_pkg::PIX_W-1:0]  base5_reg, over5_reg, wt5_reg, inv5_reg;
    logic [mopb_pkg::PROD_W-1:0] pb6_reg, po6_reg;
    logic [mopb_pkg::PROD_W-1:0] sum7_reg;
    logic [mopb_pkg::PIX_W-1:0]  pix8_reg;

    logic [mopb_pkg::PROD_W-1:0] pb6_next, po6_next, sum7_next;
    logic [mopb_pkg::PIX_W-1:0]  pix8_next;

    assign max_val  = mopb_pkg::max_of(depth_sel);
    assign half_val = max_val >> 1;

    // stage arithmetic, the sum stays below 2^32 since both weights add to max
    always_comb
    begin
        pb6_next  = mopb_pkg::PROD_W'(base5_reg) * mopb_pkg::PROD_W'(inv5_reg);
        po6_next  = mopb_pkg::PROD_W'(over5_reg) * mopb_pkg::PROD_W'(wt5_reg);
        sum7_next = pb6_reg + po6_reg + mopb_pkg::PROD_W'(half_val);
        pix8_next = mopb_pkg::div_by_max(sum7_reg, depth_sel);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else
        begin
            v5_reg <= wt_in.valid;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    // data stages
    always_ff @(posedge clk)
    begin
        base5_reg <= wt_in.base;
        over5_reg <= wt_in.over;
        wt5_reg   <= wt_in.weight;
        inv5_reg  <= max_val - wt_in.weight;

        pb6_reg   <= pb6_next;
        po6_reg   <= po6_next;

        sum7_reg  <= sum7_next;

        pix8_reg  <= pix8_next;
    end

    assign out_valid = v8_reg;
    assign out_pixel = pix8_reg;

endmodule

/* design/masked_opacity_pixel_blend_core.sv */
`timescale 1ns / 1ps
// the blended_valid strobe follows start through the weight stages and then the mix stages
// throughput: one pixel word per clock, set by the fully pipelined multipliers
// and the add-and-compare divide-by-max stages; busy is always low
// reset: valid bits cleared, depth 8 bits, opacity 0; the receiver cannot stall
// ----------------------------------------------------------------------------
// masked_opacity_pixel_blend_core
// Masked alpha blend with global opacity at 8 to 16 bits per pixel.
// ----------------------------------------------------------------------------
module masked_opacity_pixel_blend_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [mopb_pkg::PIX_W-1:0]    base_pixel,
    input  logic [mopb_pkg::PIX_W-1:0]    overlay_pixel,
    input  logic [mopb_pkg::PIX_W-1:0]    mask_value,
    output logic                          blended_valid,
    output logic [mopb_pkg::PIX_W-1:0]    blended_pixel,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [mopb_pkg::PIX_W-1:0]    cfg_data
);

    logic [mopb_pkg::DEPTH_W-1:0] depth_sel;
    logic [mopb_pkg::PIX_W-1:0]   opacity;
    mopb_pkg::mopb_wt_t           wt;

    // pipeline never stalls
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // configuration registers
    mopb_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (cfg_valid & cfg_ready),
        .wr_index  (cfg_index),
        .wr_data   (cfg_data),
        .depth_sel (depth_sel),
        .opacity   (opacity)
    );

    // effective weight stages
    mopb_weight u_weight
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (start & ~busy),
        .base_pixel    (base_pixel),
        .overlay_pixel (overlay_pixel),
        .mask_value    (mask_value),
        .depth_sel     (depth_sel),
        .opacity       (opacity),
        .wt_out        (wt)
    );

    // blend stages
    mopb_mix u_mix
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wt_in     (wt),
        .depth_sel (depth_sel),
        .out_valid (blended_valid),
        .out_pixel (blended_pixel)
    );

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for masked_opacity_pixel_blend_core. A short table of
// hand-picked pixel words covers depth and opacity extremes, the unused depth
// codes and inputs above the pixel maximum. It is followed by several hundred
// random words under changing depth and opacity, with start gaps of varying
// length. Every blended word is compared against a behavioral blend predictor
// or a value from the table.
// ----------------------------------------------------------------------------
module tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int RAND_SEGMENTS  = 10;
    localparam int SEG_WORDS      = 65;
    localparam int SEND_IDLE_A    = 38;
    localparam int SEND_IDLE_B    = 48;
    localparam int MAX_REPORTS    = 10;

    // depth codes with no size of their own, all select 16 bits
    localparam logic [mopb_pkg::DEPTH_W-1:0] DEPTH_UNUSED_5 = 3'd5;
    localparam logic [mopb_pkg::DEPTH_W-1:0] DEPTH_UNUSED_6 = 3'd6;
    localparam logic [mopb_pkg::DEPTH_W-1:0] DEPTH_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [mopb_pkg::DEPTH_W-1:0] depth;
        logic [mopb_pkg::PIX_W-1:0]   opac;
        logic [mopb_pkg::PIX_W-1:0]   base;
        logic [mopb_pkg::PIX_W-1:0]   over;
        logic [mopb_pkg::PIX_W-1:0]   mask;
        logic                         known;
        logic [mopb_pkg::PIX_W-1:0]   want;
    } blend_row_t;

    // directed words: depth, opacity, base, overlay, mask, known, blended
    localparam blend_row_t DIRECTED_ROWS [0:18] = '{
        '{mopb_pkg::DEPTH_8,  16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1, 16'h00FF},
        '{mopb_pkg::DEPTH_8,  16'h0000, 16'h0012, 16'hFFFF, 16'h00FF, 1'b1, 16'h0012},
        '{mopb_pkg::DEPTH_8,  16'h00FF, 16'h0000, 16'h00FF, 16'h00FF, 1'b1, 16'h00FF},
        '{mopb_pkg::DEPTH_8,  16'hFFFF, 16'h00FF, 16'h0000, 16'hFFFF, 1'b1, 16'h0000},
        '{mopb_pkg::DEPTH_8,  16'h0080, 16'h0010, 16'h00C8, 16'h0080, 1'b0, 16'h0000},
        '{mopb_pkg::DEPTH_8,  16'h0100, 16'h0000, 16'h00FF, 16'h00FF, 1'b1, 16'h00FF},
        '{mopb_pkg::DEPTH_10, 16'h03FF, 16'h0000, 16'h03FF, 16'h03FF, 1'b1, 16'h03FF},
        '{mopb_pkg::DEPTH_10, 16'h0200, 16'h0155, 16'h02AA, 16'h0311, 1'b0, 16'h0000},
        '{mopb_pkg::DEPTH_12, 16'h0FFF, 16'h0FFF, 16'h0000, 16'h0000, 1'b1, 16'h0FFF},
        '{mopb_pkg::DEPTH_12, 16'h0FFF, 16'h0000, 16'h0ABC, 16'hFFFF, 1'b1, 16'h0ABC},
        '{mopb_pkg::DEPTH_14, 16'h3FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'h3FFF},
        '{mopb_pkg::DEPTH_14, 16'h1234, 16'h0F0F, 16'h3000, 16'h2222, 1'b0, 16'h0000},
        '{mopb_pkg::DEPTH_16, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b1, 16'hFFFF},
        '{mopb_pkg::DEPTH_16, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF},
        '{mopb_pkg::DEPTH_16, 16'h8000, 16'h1234, 16'hFEDC, 16'h7FFF, 1'b0, 16'h0000},
        '{DEPTH_UNUSED_5,     16'hFFFF, 16'h0000, 16'hBEEF, 16'hFFFF, 1'b1, 16'hBEEF},
        '{DEPTH_UNUSED_6,     16'h0000, 16'hABCD, 16'h0000, 16'hFFFF, 1'b1, 16'hABCD},
        '{DEPTH_UNUSED_7,     16'h7FFF, 16'h5555, 16'hAAAA, 16'hFFFF, 1'b0, 16'h0000},
        '{DEPTH_UNUSED_7,     16'h7FFF, 16'hAAAA, 16'h5555, 16'h0000, 1'b1, 16'hAAAA}
    };

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [mopb_pkg::PIX_W-1:0] base_pixel = '0;
    logic [mopb_pkg::PIX_W-1:0] overlay_pixel = '0;
    logic [mopb_pkg::PIX_W-1:0] mask_value = '0;
    logic                       blended_valid;
    logic [mopb_pkg::PIX_W-1:0] blended_pixel;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic                       cfg_index = mopb_pkg::REG_DEPTH;
    logic [mopb_pkg::PIX_W-1:0] cfg_data = '0;

    // register copies as the block should hold them
    logic [mopb_pkg::DEPTH_W-1:0] cur_depth = mopb_pkg::DEPTH_8;
    logic [mopb_pkg::PIX_W-1:0]   cur_opac = '0;

    logic [mopb_pkg::PIX_W-1:0] pending_blend [$];
    logic [mopb_pkg::PIX_W-1:0] want_pix;
    int                         mismatch_count = 0;
    int                         quiet_cycles = 0;

    masked_opacity_pixel_blend_core u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .base_pixel    (base_pixel),
        .overlay_pixel (overlay_pixel),
        .mask_value    (mask_value),
        .blended_valid (blended_valid),
        .blended_pixel (blended_pixel),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // pixel maximum for a depth code
    function automatic longint unsigned pix_max(input logic [mopb_pkg::DEPTH_W-1:0] depth);
        int unsigned bits;
        begin
            bits = (depth > mopb_pkg::DEPTH_16) ? 16 : 8 + 2 * depth;
            return (64'd1 << bits) - 64'd1;
        end
    endfunction

    // blended word for the given registers and pixel word
    function automatic logic [mopb_pkg::PIX_W-1:0] blend_expect(
        input logic [mopb_pkg::DEPTH_W-1:0] depth,
        input logic [mopb_pkg::PIX_W-1:0]   opac,
        input logic [mopb_pkg::PIX_W-1:0]   b,
        input logic [mopb_pkg::PIX_W-1:0]   o,
        input logic [mopb_pkg::PIX_W-1:0]   mk);
        longint unsigned mx;
        longint unsigned hf;
        longint unsigned bs;
        longint unsigned ov;
        longint unsigned mw;
        longint unsigned op;
        longint unsigned wt;
        longint unsigned mix;
        begin
            mx = pix_max(depth);
            hf = mx >> 1;
            // inputs above the maximum are clamped
            bs = (b > mx) ? mx : b;
            ov = (o > mx) ? mx : o;
            mw = (mk > mx) ? mx : mk;
            op = (opac > mx) ? mx : opac;
            wt = (mw * op + hf) / mx;
            if (wt > mx)
                wt = mx;
            mix = (bs * (mx - wt) + ov * wt + hf) / mx;
            if (mix > mx)
                mix = mx;
            return mopb_pkg::PIX_W'(mix);
        end
    endfunction

    // random pixel value, biased toward the ends of the range
    function automatic logic [mopb_pkg::PIX_W-1:0] pick_pix(input longint unsigned mx);
        begin
            case ($urandom_range(9))
                0:       return '0;
                1:       return mopb_pkg::PIX_W'(mx);
                2:       return mopb_pkg::PIX_W'($urandom_range(16'hFFFF));
                default: return mopb_pkg::PIX_W'($urandom_range(32'(mx)));
            endcase
        end
    endfunction

    // config write, valid left high for the caller to drop
    task automatic write_reg(input logic idx, input logic [mopb_pkg::PIX_W-1:0] data);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            if (idx == mopb_pkg::REG_DEPTH)
                cur_depth = data[mopb_pkg::DEPTH_W-1:0];
            else
                cur_opac = data;
        end
    endtask

    // stop sending and let every expected word come out
    task automatic wait_idle;
        begin
            start <= 1'b0;
            while (pending_blend.size() != 0)
                @(posedge clk);
        end
    endtask

    // move to new register values, only while the pipeline is empty
    task automatic apply_config(input logic [mopb_pkg::DEPTH_W-1:0] depth,
                                input logic [mopb_pkg::PIX_W-1:0] opac);
        logic [mopb_pkg::PIX_W-1:0] data;
        begin
            if (depth != cur_depth || opac != cur_opac)
            begin
                wait_idle();
                if (depth != cur_depth)
                begin
                    // upper data bits are don't-care for the depth register
                    data = mopb_pkg::PIX_W'($urandom_range(16'hFFFF));
                    data[mopb_pkg::DEPTH_W-1:0] = depth;
                    write_reg(mopb_pkg::REG_DEPTH, data);
                end
                if (opac != cur_opac)
                    write_reg(mopb_pkg::REG_OPACITY, opac);
                cfg_valid <= 1'b0;
            end
        end
    endtask

    // one pixel word, start left high for the caller to drop
    task automatic send_word(input logic [mopb_pkg::PIX_W-1:0] b,
                             input logic [mopb_pkg::PIX_W-1:0] o,
                             input logic [mopb_pkg::PIX_W-1:0] mk, input logic known,
                             input logic [mopb_pkg::PIX_W-1:0] want);
        begin
            start         <= 1'b1;
            base_pixel    <= b;
            overlay_pixel <= o;
            mask_value    <= mk;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            if (known)
                pending_blend.push_back(want);
            else
                pending_blend.push_back(blend_expect(cur_depth, cur_opac, b, o, mk));
        end
    endtask

    // compare each blended word with the oldest expected one
    always @(posedge clk)
    begin
        if (rst_n && blended_valid)
        begin
            if (pending_blend.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected blended word %h at %0t", blended_pixel, $time);
            end
            else
            begin
                want_pix = pending_blend.pop_front();
                if (blended_pixel !== want_pix)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("blended_pixel mismatch: expected %h actual %h at %0t",
                                 want_pix, blended_pixel, $time);
                end
            end
        end
    end

    // watchdog on cycles with no handshake of any kind
    always @(posedge clk)
    begin
        if ((start && !busy) || blended_valid || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // stimulus
    initial
    begin : stim
        logic [mopb_pkg::DEPTH_W-1:0] depth;
        logic [mopb_pkg::PIX_W-1:0]   opac;
        longint unsigned              mx;
        int                           pct;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, back to back while the registers stay the same
        for (int i = 0; i < $size(DIRECTED_ROWS); i++)
        begin
            apply_config(DIRECTED_ROWS[i].depth, DIRECTED_ROWS[i].opac);
            send_word(DIRECTED_ROWS[i].base, DIRECTED_ROWS[i].over, DIRECTED_ROWS[i].mask,
                      DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].want);
        end

        // random segments, each under its own register setting
        for (int seg = 0; seg < RAND_SEGMENTS; seg++)
        begin
            if (seg == 0)
                depth = mopb_pkg::DEPTH_8;
            else if (seg == 1)
                depth = mopb_pkg::DEPTH_16;
            else
                depth = mopb_pkg::DEPTH_W'($urandom_range(7));
            mx = pix_max(depth);
            if (seg == 0)
                opac = mopb_pkg::PIX_W'(mx);
            else if (seg == 1)
                opac = '0;
            else
            begin
                case ($urandom_range(4))
                    0:       opac = '0;
                    1:       opac = mopb_pkg::PIX_W'(mx);
                    2:       opac = mopb_pkg::PIX_W'($urandom_range(16'hFFFF));
                    default: opac = mopb_pkg::PIX_W'($urandom_range(32'(mx)));
                endcase
            end
            apply_config(depth, opac);

            // sender idles in pct cycles of a hundred, then none at the end
            pct = (seg < 4) ? SEND_IDLE_A : ((seg < 7) ? SEND_IDLE_B : 0);
            for (int n = 0; n < SEG_WORDS; n++)
            begin
                while ($urandom_range(99) < pct)
                begin
                    start <= 1'b0;
                    @(posedge clk);
                end
                send_word(pick_pix(mx), pick_pix(mx), pick_pix(mx), 1'b0, '0);
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
